@@ hw/rtl/mca_pkg.sv @@
// ----------------------------------------------------------------------------
// mca_pkg
// Shared types and constants of the modular coefficient ALU.
// ----------------------------------------------------------------------------
package mca_pkg;

  localparam int ModBits   = 62;
  localparam int XBits     = 126;  // widest value handed to the reducer
  localparam int RecipBits = 128;  // Barrett shift k, reciprocal floor(2^k / q)
  localparam int RemBits   = 64;   // partial remainder, below 3q

  localparam logic [ModBits-1:0]   ModReset   = ModBits'(12289);
  localparam logic [RecipBits-1:0] RecipReset =
    RecipBits'((129'd1 << RecipBits) / 129'd12289);

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpRed = 2'd3
  } op_e;

  // register levels of mca_mul: partial products, then a binary adder tree
  function automatic int mul_lat(int aw, int bw);
    return $clog2(((aw + 31) >> 5) * ((bw + 31) >> 5)) + 1;
  endfunction

endpackage

@@ hw/rtl/mca_mul.sv @@
// ----------------------------------------------------------------------------
// mca_mul
// Pipelined unsigned multiplier: 32x32 partial products, registered adder tree.
// ----------------------------------------------------------------------------
module mca_mul import mca_pkg::*; #(
  parameter int AW = 64,
  parameter int BW = 62
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int NA = (AW + 31) / 32;
  localparam int NB = (BW + 31) / 32;
  localparam int NT = NA * NB;
  localparam int LV = $clog2(NT);
  localparam int NP = 1 << LV;
  localparam int PW = AW + BW;

  logic [NA*32-1:0] a_ext;
  logic [NB*32-1:0] b_ext;
  logic [PW-1:0]    sum_q [LV+1][NP];

  assign a_ext = (NA*32)'(a_i);
  assign b_ext = (NB*32)'(b_i);

  for (genvar gp = 0; gp < NP; gp++) begin : g_pp
    if (gp < NT) begin : g_prod
      localparam int IA = gp / NB;
      localparam int IB = gp % NB;
      localparam int SH = 32 * (IA + IB);
      logic [31:0] x;
      logic [31:0] y;
      logic [63:0] pp;
      assign x  = a_ext[IA*32 +: 32];
      assign y  = b_ext[IB*32 +: 32];
      assign pp = 64'(x) * 64'(y);
      always_ff @(posedge clk_i) begin
        sum_q[0][gp] <= PW'(pp) << SH;
      end
    end else begin : g_zero
      always_ff @(posedge clk_i) begin
        sum_q[0][gp] <= '0;
      end
    end
  end

  for (genvar gl = 0; gl < LV; gl++) begin : g_lvl
    for (genvar gj = 0; gj < (NP >> (gl + 1)); gj++) begin : g_add
      always_ff @(posedge clk_i) begin
        sum_q[gl+1][gj] <= sum_q[gl][2*gj] + sum_q[gl][2*gj+1];
      end
    end
  end

  assign p_o = sum_q[LV][0];

endmodule

@@ hw/rtl/mca_recip.sv @@
// ----------------------------------------------------------------------------
// mca_recip
// Modulus register and bit-serial divider for the Barrett reciprocal.
// ----------------------------------------------------------------------------
module mca_recip import mca_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [ModBits-1:0]   cfg_data_i,
  output logic                 busy_o,
  output logic [ModBits-1:0]   modulus_o,
  output logic [RecipBits-1:0] recip_o
);

  localparam int CntBits = $clog2(RecipBits + 1);

  logic                 busy_q;
  logic [CntBits-1:0]   cnt_q;
  logic [ModBits-1:0]   rem_q;
  logic [ModBits-1:0]   modulus_q;
  logic [RecipBits-1:0] recip_q;
  logic [ModBits:0]     rem_sh;
  logic                 ge;
  logic [ModBits:0]     rem_sub;

  // dividend is 2^k: one set bit at the first step
  assign rem_sh  = {rem_q, (cnt_q == CntBits'(RecipBits))};
  assign ge      = rem_sh >= {1'b0, modulus_q};
  assign rem_sub = rem_sh - {1'b0, modulus_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      modulus_q <= ModReset;
      recip_q   <= RecipReset;
    end else if (cfg_valid_i && !busy_q) begin
      busy_q    <= 1'b1;
      cnt_q     <= CntBits'(RecipBits);
      modulus_q <= cfg_data_i;
    end else if (busy_q) begin
      recip_q <= {recip_q[RecipBits-2:0], ge};
      cnt_q   <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cfg_valid_i && !busy_q) begin
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[ModBits-1:0] : rem_sh[ModBits-1:0];
    end
  end

  assign cfg_ready_o = !busy_q;
  assign busy_o      = busy_q;
  assign modulus_o   = modulus_q;
  assign recip_o     = recip_q;

endmodule

@@ hw/rtl/modular_coefficient_alu.sv @@
// ----------------------------------------------------------------------------
// modular_coefficient_alu
// Add, subtract, multiply and reduce modulo q, Barrett reduction, pipelined.
// ----------------------------------------------------------------------------
//  channel   ports                                        handshake
//  request   start_i, req_type_i, operand_a_i, operand_b_i  start_i & !busy_o
//  result    done_o, residue_o                             strobe, no backpressure
//  modulus   cfg_valid_i, cfg_ready_o, cfg_data_i          valid & ready
//
// One request per cycle while busy_o is low; each request passes the three multiplier
// trees and the registered Barrett correction steps.
// A modulus write runs a bit-serial divider; busy_o is high while it runs.
// Reset loads q=12289 and its reciprocal; no clearing pass.
// No stalls: the result side always takes the beat.
// ----------------------------------------------------------------------------
module modular_coefficient_alu import mca_pkg::*; #(
  parameter int WORD_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            req_type_i,
  input  logic [WORD_WIDTH-1:0] operand_a_i,
  input  logic [ModBits-1:0]    operand_b_i,
  output logic                  done_o,
  output logic [ModBits-1:0]    residue_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [ModBits-1:0]    cfg_data_i
);

  localparam int LA = mul_lat(WORD_WIDTH, ModBits);
  localparam int LB = mul_lat(XBits, RecipBits);
  localparam int LC = mul_lat(RemBits, ModBits);
  localparam int LatTotal = LA + LB + LC + 4;

  logic [ModBits-1:0]   modulus;
  logic [RecipBits-1:0] recip;
  logic                 accept;
  logic                 q_small;
  logic [XBits-1:0]     xlin;
  logic [WORD_WIDTH+ModBits-1:0] prod_ab;
  logic [XBits+RecipBits-1:0]    prod_xm;
  logic [RemBits+ModBits-1:0]    prod_qq;
  logic [RemBits-1:0]   q_ext;

  logic                 a_vld_q [LA];
  logic [1:0]           a_op_q  [LA];
  logic [XBits-1:0]     a_x_q   [LA];
  logic                 x_vld_q;
  logic [XBits-1:0]     x_q;
  logic                 b_vld_q [LB];
  logic [RemBits-1:0]   b_x_q   [LB];
  logic                 c_vld_q [LC];
  logic [RemBits-1:0]   c_x_q   [LC];
  logic                 r_vld_q, s_vld_q, done_q;
  logic [RemBits-1:0]   r_q, s_q, res_q;

  mca_recip u_recip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy_o),
    .modulus_o   (modulus),
    .recip_o     (recip)
  );

  assign accept  = start_i && !busy_o;
  assign q_small = modulus <= ModBits'(1);
  assign q_ext   = RemBits'(modulus);

  // add, subtract and reduce form the value to reduce directly; q*2^62 > b
  always_comb begin
    unique case (op_e'(req_type_i))
      OpAdd:   xlin = XBits'(operand_a_i) + XBits'(operand_b_i);
      OpSub:   xlin = XBits'(operand_a_i) + (XBits'(modulus) << ModBits)
                      - XBits'(operand_b_i);
      OpRed:   xlin = XBits'(operand_a_i);
      default: xlin = '0;
    endcase
  end

  mca_mul #(.AW(WORD_WIDTH), .BW(ModBits)) u_mul_ab (
    .clk_i (clk_i),
    .a_i   (operand_a_i),
    .b_i   (operand_b_i),
    .p_o   (prod_ab)
  );

  mca_mul #(.AW(XBits), .BW(RecipBits)) u_mul_xm (
    .clk_i (clk_i),
    .a_i   (x_q),
    .b_i   (recip),
    .p_o   (prod_xm)
  );

  // only the low bits of quotient * q matter: the remainder is below 3q < 2^64
  mca_mul #(.AW(RemBits), .BW(ModBits)) u_mul_qq (
    .clk_i (clk_i),
    .a_i   (prod_xm[RecipBits +: RemBits]),
    .b_i   (modulus),
    .p_o   (prod_qq)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LA; i++) a_vld_q[i] <= 1'b0;
      for (int i = 0; i < LB; i++) b_vld_q[i] <= 1'b0;
      for (int i = 0; i < LC; i++) c_vld_q[i] <= 1'b0;
      x_vld_q <= 1'b0;
      r_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      a_vld_q[0] <= accept;
      for (int i = 1; i < LA; i++) a_vld_q[i] <= a_vld_q[i-1];
      x_vld_q    <= a_vld_q[LA-1];
      b_vld_q[0] <= x_vld_q;
      for (int i = 1; i < LB; i++) b_vld_q[i] <= b_vld_q[i-1];
      c_vld_q[0] <= b_vld_q[LB-1];
      for (int i = 1; i < LC; i++) c_vld_q[i] <= c_vld_q[i-1];
      r_vld_q <= c_vld_q[LC-1];
      s_vld_q <= r_vld_q;
      done_q  <= s_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_op_q[0] <= req_type_i;
    a_x_q[0]  <= xlin;
    for (int i = 1; i < LA; i++) begin
      a_op_q[i] <= a_op_q[i-1];
      a_x_q[i]  <= a_x_q[i-1];
    end
    x_q <= (op_e'(a_op_q[LA-1]) == OpMul) ? XBits'(prod_ab) : a_x_q[LA-1];
    b_x_q[0] <= x_q[RemBits-1:0];
    for (int i = 1; i < LB; i++) b_x_q[i] <= b_x_q[i-1];
    c_x_q[0] <= b_x_q[LB-1];
    for (int i = 1; i < LC; i++) c_x_q[i] <= c_x_q[i-1];
    r_q   <= c_x_q[LC-1] - prod_qq[RemBits-1:0];
    s_q   <= (r_q >= q_ext) ? r_q - q_ext : r_q;
    res_q <= q_small ? '0 : ((s_q >= q_ext) ? s_q - q_ext : s_q);
  end

  assign done_o    = done_q;
  assign residue_o = res_q[ModBits-1:0];

`ifndef SYNTH
  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !q_small |-> residue_o < modulus)
    else $error("residue not below modulus");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> busy_o)
    else $error("modulus write did not start the divider");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(LatTotal) done_o)
    else $error("request beat lost in pipeline");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LatTotal))
    else $error("result beat without request");
`endif

endmodule

@@ dv/modular_coefficient_alu_tb.sv @@
// ----------------------------------------------------------------------------
// modular_coefficient_alu_tb
// Drives add, subtract, multiply and reduce requests under several moduli,
// predicts each residue with exact modular arithmetic and checks every result
// beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_coefficient_alu_tb import mca_pkg::*; ();

  localparam int WordW = 64;
  localparam int Latency = 15;
  localparam int WatchLimit = 4000;

  class residue_scoreboard;
    logic [ModBits-1:0] q = ModReset;
    logic [ModBits-1:0] pending[$];
    int mismatches = 0;
    int strays = 0;

    function logic [ModBits-1:0] mod_result(op_e op, logic [WordW-1:0] a,
                                            logic [ModBits-1:0] b);
      logic [127:0] ar, br, r;
      if (q == 0) return '0;
      ar = a % q;
      br = b % q;
      case (op)
        OpAdd: r = (ar + br) % q;
        OpSub: r = (ar + q - br) % q;
        OpMul: r = (ar * br) % q;
        default: r = ar;
      endcase
      return r[ModBits-1:0];
    endfunction

    function void note_request(op_e op, logic [WordW-1:0] a, logic [ModBits-1:0] b);
      pending.push_back(mod_result(op, a, b));
    endfunction

    function void check_residue(logic [ModBits-1:0] got);
      logic [ModBits-1:0] want;
      if (pending.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches + strays <= 10)
          $display("residue mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic start_i, busy_o, done_o, cfg_valid_i, cfg_ready_o;
  logic [1:0] req_type_i;
  logic [WordW-1:0] operand_a_i;
  logic [ModBits-1:0] operand_b_i, residue_o, cfg_data_i;

  residue_scoreboard sb = new();
  int idle_pct = 0;
  int quiet = 0;

  modular_coefficient_alu #(.WORD_WIDTH(WordW)) i_dut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_residue(residue_o);
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WatchLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // start_i stays high between back-to-back beats; idling and drain lower it
  task automatic send(op_e op, logic [WordW-1:0] a, logic [ModBits-1:0] b);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start_i <= 0;
      @(posedge clk_i);
    end
    start_i <= 1;
    req_type_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(op, a, b);
  endtask

  task automatic drain();
    start_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_modulus(logic [ModBits-1:0] q);
    drain();
    cfg_valid_i <= 1;
    cfg_data_i <= q;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    sb.q = q;
  endtask

  // operand q-1, a value mod q or 0..2 most of the time, any value now and then
  function automatic logic [63:0] pick_operand(int width);
    logic [63:0] v;
    v = rand64();
    if (width < 64) v = v & ((64'd1 << width) - 1);
    if (sb.q > 1 && $urandom_range(9, 0) < 7) begin
      case ($urandom_range(3, 0))
        0: v = sb.q - 1;
        1: v = v % sb.q;
        2: v = $urandom_range(2, 0);
        default: v = v % sb.q;
      endcase
    end
    return v;
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++)
      send(op_e'($urandom_range(3, 0)), pick_operand(64), pick_operand(ModBits));
  endtask

  logic [ModBits-1:0] moduli[8];

  initial begin
    logic [ModBits-1:0] qmax;
    qmax = '1;
    start_i = 0; cfg_valid_i = 0; req_type_i = OpAdd;
    operand_a_i = '0; operand_b_i = '0; cfg_data_i = '0;
    rst_ni = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset modulus, moduli qmax, 0, 1 and 2, extremes and every operation
    send(OpAdd, 0, 0);
    send(OpAdd, 12288, 12288);
    send(OpSub, 0, 12288);
    send(OpSub, 5, 5);
    send(OpMul, 12288, 12288);
    send(OpMul, 1, 777);
    send(OpMul, 0, 12288);
    send(OpRed, '1, 0);
    send(OpRed, 64'h8000_0000_0000_0000, qmax);
    send(OpAdd, '1, qmax);
    send(OpSub, '1, qmax);
    send(OpMul, '1, qmax);
    write_modulus(qmax);
    send(OpMul, qmax - 1, qmax - 1);
    send(OpSub, 0, qmax - 1);
    send(OpAdd, qmax - 1, qmax - 1);
    send(OpRed, '1, 0);
    send(OpMul, '1, qmax);
    write_modulus(0);
    send(OpMul, 123, 45);
    send(OpRed, '1, 0);
    write_modulus(1);
    send(OpAdd, 3, 4);
    write_modulus(2);
    send(OpSub, 0, 1);
    send(OpMul, '1, qmax);

    moduli = '{62'd12289, 62'd3329, 62'd8380417, qmax, 62'd2,
               62'h3fff_ffff_ffff_ffc5, 62'd4294967291, 62'd1};
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) idle_pct = 34;
      else if (ph < 6) idle_pct = 69;
      else idle_pct = 0;
      if (ph == 4) drain();  // sender holds off until all results are in
      write_modulus(ph < 8 ? moduli[ph] : {$urandom(), $urandom()} & qmax);
      random_run(ph == 7 ? 20 : 230);
    end

    drain();
    if (sb.mismatches == 0 && sb.strays == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
